FILE: hdl/assert_macros.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/blifo_pkg.sv
package blifo_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_PEEK = 1'b1
  } state_t;

  localparam int unsigned CAP_RESET = 64;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] push_value;
    logic [6:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               empty_res;
    logic               full_res;
    logic [6:0]         count;
  } out_t;

  // one control word broadcast along the row
  typedef struct packed {
    logic push;
    logic pop;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hdl/bounded_lifo_stack_unit.sv
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_data  (kind, push_value, position)
// out     | out | out_valid/out_stall| out_data (read_value, status, flags, count)
// cfg     | in  | cfg_we             | cfg_wdata (capacity)
// Push, pop, error and no-op items: the result is registered when the item is accepted.
// Peek at position p: the read lane of the cell row is loaded, then shifts one cell a cycle until word p is at the top.
// One item in flight; in_stall is high while a peek walks the row or the result is held.
// Reset (synchronous, rst_n low): stack empty, capacity 64, no result pending.
module bounded_lifo_stack_unit #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  blifo_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output blifo_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata
);

`include "assert_macros.svh"

  logic [31:0] words [DEPTH];
  logic [31:0] rds   [DEPTH];
  blifo_pkg::cell_ctrl_t ctrl;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] up_w, dn_w, rdn_w;
    if (i == 0) begin : g_top
      assign up_w = in_data.push_value;
    end else begin : g_mid
      assign up_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign dn_w  = '0;
      assign rdn_w = '0;
    end else begin : g_link
      assign dn_w  = words[i+1];
      assign rdn_w = rds[i+1];
    end
    blifo_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .word_up_i (up_w),
      .word_dn_i (dn_w),
      .rd_dn_i   (rdn_w),
      .word_o    (words[i]),
      .rd_o      (rds[i])
    );
  end

  blifo_pkg::state_t state_r, state_nxt;
  logic [6:0]        level_r, level_nxt;
  logic [6:0]        cap_r, cap_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  blifo_pkg::out_t   out_data_r, out_data_nxt;
  logic [6:0]        cap_eff;
  logic              in_acc, out_free, out_load;
  logic [31:0]       value;
  logic [1:0]        status;

  assign cap_eff  = (int'(cap_r) > DEPTH) ? 7'(DEPTH) : cap_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != blifo_pkg::S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    out_load  = 1'b0;
    value     = '0;
    status    = blifo_pkg::ST_OK;
    cap_nxt   = cfg_we ? cfg_wdata : cap_r;
    unique case (state_r)
      blifo_pkg::S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (blifo_pkg::kind_t'(in_data.kind))
            blifo_pkg::KIND_PUSH: begin
              if (level_r >= cap_eff) begin
                status = blifo_pkg::ST_OVERFLOW;
              end else begin
                ctrl.push = 1'b1;
                level_nxt = level_r + 7'd1;
              end
            end
            blifo_pkg::KIND_POP: begin
              if (level_r == 7'd0) begin
                status = blifo_pkg::ST_UNDERFLOW;
              end else begin
                ctrl.pop  = 1'b1;
                value     = words[0];
                level_nxt = level_r - 7'd1;
              end
            end
            blifo_pkg::KIND_PEEK: begin
              if (in_data.position == 7'd0 || in_data.position > level_r) begin
                status = blifo_pkg::ST_BADPOS;
              end else begin
                ctrl.load = 1'b1;
                cnt_nxt   = in_data.position - 7'd1;
                state_nxt = blifo_pkg::S_PEEK;
                out_load  = 1'b0;
              end
            end
            blifo_pkg::KIND_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      blifo_pkg::S_PEEK: begin
        if (cnt_r == 7'd0) begin
          if (out_free) begin
            out_load  = 1'b1;
            value     = rds[0];
            state_nxt = blifo_pkg::S_IDLE;
          end
        end else begin
          ctrl.shift = 1'b1;
          cnt_nxt    = cnt_r - 7'd1;
        end
      end
      default: begin
        state_nxt = blifo_pkg::S_IDLE;
      end
    endcase

    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt.read_value = value;
      out_data_nxt.status     = status;
      out_data_nxt.empty_res  = (level_nxt == 7'd0);
      out_data_nxt.full_res   = (level_nxt >= cap_eff);
      out_data_nxt.count      = level_nxt;
    end
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blifo_pkg::S_IDLE;
      level_r     <= '0;
      cap_r       <= 7'(blifo_pkg::CAP_RESET);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_level_step, 1'b1, (level_r == $past(level_r)) || (level_r == $past(level_r) + 7'd1) || (level_r == $past(level_r) - 7'd1), "level moved by more than one")
  `ASSERT_ALWAYS(a_peek_depth, (state_r != blifo_pkg::S_PEEK) || (cnt_r < level_r), "peek walk beyond held words")
  `ASSERT_NEXT(a_peek_hold, state_r == blifo_pkg::S_PEEK, $stable(level_r), "level changed during peek")
  `ASSERT_NEXT(a_peek_start, in_acc && ctrl.load, state_r == blifo_pkg::S_PEEK, "peek did not start walk")

endmodule

FILE: hdl/blifo_cell.sv
module blifo_cell (
  input  logic                   clk,
  input  blifo_pkg::cell_ctrl_t  ctrl,
  input  logic [31:0]            word_up_i,
  input  logic [31:0]            word_dn_i,
  input  logic [31:0]            rd_dn_i,
  output logic [31:0]            word_o,
  output logic [31:0]            rd_o
);

  logic [31:0] word_r, word_nxt;
  logic [31:0] rd_r, rd_nxt;

  always_comb begin
    word_nxt = word_r;
    rd_nxt   = rd_r;
    priority if (ctrl.push) begin
      word_nxt = word_up_i;
    end else if (ctrl.pop) begin
      word_nxt = word_dn_i;
    end else begin
      word_nxt = word_r;
    end
    priority if (ctrl.load) begin
      rd_nxt = word_r;
    end else if (ctrl.shift) begin
      rd_nxt = rd_dn_i;
    end else begin
      rd_nxt = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rd_r   <= rd_nxt;
  end

  assign word_o = word_r;
  assign rd_o   = rd_r;

endmodule
